// File: rtl/vsps_pkg.sv
package vsps_pkg;

  // Field widths fixed by the interface
  localparam int SPEED_W    = 9;
  localparam int RPM_W      = 14;
  localparam int GEAR_W     = 3;
  localparam int INTERVAL_W = 17;
  localparam int SHIFT_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Divider geometry: 31-bit dividend, divisors up to 511 * 12200 (23 bits)
  localparam int QUOT_W = 31;
  localparam int DIVR_W = 23;
  localparam int PROD_W = 23;
  localparam int PROD5_W = 25;
  localparam int RATIO_W = 14;

  // rpm = (s*r*5 >> 1) / 303, done as a multiply by ceil(2^33/303) and a shift;
  // exact for any 24-bit halved product
  localparam int RPM_HALF_W  = PROD5_W - 1;
  localparam int RPM_RECIP_W = 25;
  localparam int RPM_FULL_W  = RPM_HALF_W + RPM_RECIP_W;
  localparam int RPM_SHIFT   = 33;
  localparam logic [RPM_RECIP_W-1:0] RPM_RECIP = 25'd28349620;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_RPM       = 2'd2;

  localparam logic [INTERVAL_W-1:0] UPDATE_INTERVAL_RST = 17'd100000;
  localparam logic [SPEED_W-1:0]    SPEED_LIMIT_RST     = 9'd350;
  localparam logic [SHIFT_W-1:0]    SHIFT_RPM_RST       = 13'd6000;
  localparam logic [SPEED_W-1:0]    SPEED_RST           = 9'd50;

  // Gear ratios in thousandths; gears past the fifth reuse the fifth ratio
  localparam logic [RATIO_W-1:0] GEAR_RATIO [8] = '{
    14'd12200, 14'd6908, 14'd4383, 14'd3271,
    14'd2620, 14'd2620, 14'd2620, 14'd2620
  };

  // Numerators, pre-divided by the fixed factors of each divisor
  // floor(1e8/146), 1212000000, floor(72720000000/552)
  localparam logic [QUOT_W-1:0] SPEED_NUM   = 31'd684931;
  localparam logic [QUOT_W-1:0] ENGINE_NUM  = 31'd1212000000;
  localparam logic [QUOT_W-1:0] AIRFLOW_NUM = 31'd131739130;
  localparam logic [DIVR_W-1:0] SHIFT_MUL   = 23'd606;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPEED,
    ST_GMUL,
    ST_GCMP,
    ST_RPM,
    ST_DLOAD,
    ST_DIV,
    ST_DSTORE,
    ST_CHAN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DOP_SPEED,
    DOP_ENGINE,
    DOP_AIRFLOW
  } div_op_t;

  typedef struct packed {
    logic plus_pressed;
    logic minus_pressed;
  } in_t;

  typedef struct packed {
    logic               speed_pulse;
    logic               rpm_pulse;
    logic               airflow_pulse;
    logic [SPEED_W-1:0] speed_kmh;
    logic [RPM_W-1:0]   engine_rpm;
    logic [GEAR_W-1:0]  gear_index;
  } out_t;

endpackage

// File: rtl/vehicle_sensor_pulse_stimulator_top.sv
// Sequence: a plain tick runs the wave update step, then the emit step that loads the
//   result; a recompute tick samples the buttons, tries gears (multiply, compare),
//   computes rpm and runs three divider quotients (skipped at zero speed) first.
// Transactions: one at a time, set by the shared bit-serial divider (one quotient bit
//   per step, 31-bit quotients, three quotients per recompute); a new tick is accepted
//   only once the result has loaded and the block is back in idle; a stalled result
//   holds the block in its emit step.
// Reset: rst_n synchronous active low; registers to their defaults, speed 50,
//   all waves low and disabled, counters cleared, no pending result.
module vehicle_sensor_pulse_stimulator_top #(
  parameter int GEAR_COUNT  = 5,
  parameter int PERIOD_BITS = 20
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input tick channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  vsps_pkg::in_t                         in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output vsps_pkg::out_t                        out_data,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [vsps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vsps_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import vsps_pkg::*;

  localparam logic [GEAR_W-1:0]      LAST_GEAR  = GEAR_W'(GEAR_COUNT - 1);
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;
  localparam int                     CNT_W      = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0]       CNT_LAST   = CNT_W'(QUOT_W - 1);
  localparam int                     RPM_QUO_W  = RPM_FULL_W - RPM_SHIFT;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  // configuration
  logic [INTERVAL_W-1:0] update_interval_r;
  logic [SPEED_W-1:0]    speed_limit_r;
  logic [SHIFT_W-1:0]    shift_rpm_r;

  // simulation state
  logic [SPEED_W-1:0]     speed_r, speed_nxt;
  logic [RPM_W-1:0]       rpm_r, rpm_nxt;
  logic [GEAR_W-1:0]      gear_r, gear_nxt;
  logic [INTERVAL_W-1:0]  interval_r, interval_nxt;
  logic [PERIOD_BITS-1:0] hp_r [3];
  logic [PERIOD_BITS-1:0] hp_nxt [3];
  logic [PERIOD_BITS-1:0] ch_el_r [3];
  logic [PERIOD_BITS-1:0] ch_el_nxt [3];
  logic [2:0]             level_r, level_nxt;

  // sequencer working registers (no reset needed)
  logic                  plus_r, plus_nxt;
  logic                  minus_r, minus_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [DIVR_W-1:0]     lim_r, lim_nxt;
  logic [QUOT_W-1:0]     quot_r, quot_nxt;
  logic [DIVR_W-1:0]     rem_r, rem_nxt;
  logic [DIVR_W-1:0]     div_r, div_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  div_op_t               op_r, op_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------------
  // Shared combinational terms
  // ---------------------------------------------------------------------------
  logic                 in_acc;
  logic                 out_free;
  logic                 due;        // this tick triggers a recompute
  logic [PROD5_W-1:0]   prod5;      // s * r * 5
  logic                 gear_ok;
  logic [DIVR_W:0]      trial;      // one restoring-division step
  logic                 trial_ge;
  logic [DIVR_W:0]      trial_diff;
  logic [RPM_FULL_W-1:0] rpm_full;  // (s*r*5/2) * reciprocal of 303
  logic [RPM_QUO_W-1:0]  rpm_quo;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign due       = (interval_r >= update_interval_r);
  assign prod5     = {prod_r, 2'b00} + PROD5_W'(prod_r);
  assign gear_ok   = (prod5 < {2'b00, lim_r});
  assign trial      = {rem_r, quot_r[QUOT_W-1]};
  assign trial_ge   = (trial >= {1'b0, div_r});
  assign trial_diff = trial - {1'b0, div_r};
  assign rpm_full   = RPM_FULL_W'(prod5[PROD5_W-1:1]) * RPM_FULL_W'(RPM_RECIP);
  assign rpm_quo    = rpm_full[RPM_FULL_W-1:RPM_SHIFT];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = due ? ST_SPEED : ST_CHAN;
      end
      ST_SPEED: state_nxt = ST_GMUL;
      ST_GMUL:  state_nxt = ST_GCMP;
      ST_GCMP: begin
        // stop at the first gear under the shift limit, or at the last gear
        if (gear_ok || gear_r >= LAST_GEAR) state_nxt = ST_RPM;
        else                               state_nxt = ST_GMUL;
      end
      ST_RPM: begin
        // zero speed skips the half-period quotients entirely
        if (speed_r == '0) state_nxt = ST_CHAN;
        else               state_nxt = ST_DLOAD;
      end
      ST_DLOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_DSTORE;
      end
      ST_DSTORE: begin
        if (op_r == DOP_AIRFLOW) state_nxt = ST_CHAN;
        else                     state_nxt = ST_DLOAD;
      end
      ST_CHAN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    speed_nxt     = speed_r;
    rpm_nxt       = rpm_r;
    gear_nxt      = gear_r;
    interval_nxt  = interval_r;
    hp_nxt        = hp_r;
    ch_el_nxt     = ch_el_r;
    level_nxt     = level_r;
    plus_nxt      = plus_r;
    minus_nxt     = minus_r;
    prod_nxt      = prod_r;
    lim_nxt       = lim_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          plus_nxt  = in_data.plus_pressed;
          minus_nxt = in_data.minus_pressed;
          if (due) interval_nxt = '0;
          else     interval_nxt = interval_r + 1'b1;
        end
      end

      ST_SPEED: begin
        // plus first, then minus sees the updated speed
        speed_nxt = speed_r;
        if (plus_r && speed_r < speed_limit_r) speed_nxt = speed_r + 1'b1;
        if (minus_r && speed_nxt != '0)        speed_nxt = speed_nxt - 1'b1;
        gear_nxt = '0;
        lim_nxt  = DIVR_W'(shift_rpm_r) * SHIFT_MUL;
      end

      ST_GMUL: begin
        prod_nxt = PROD_W'(speed_r) * PROD_W'(GEAR_RATIO[gear_r]);
      end

      ST_GCMP: begin
        if (!gear_ok && gear_r < LAST_GEAR) gear_nxt = gear_r + 1'b1;
      end

      ST_RPM: begin
        rpm_nxt = (rpm_quo[RPM_QUO_W-1:RPM_W] != '0) ? '1 : rpm_quo[RPM_W-1:0];
        if (speed_r == '0) begin
          for (int i = 0; i < 3; i++) hp_nxt[i] = '0;
        end
        op_nxt = DOP_SPEED;
      end

      ST_DLOAD: begin
        rem_nxt = '0;
        cnt_nxt = '0;
        unique case (op_r)
          DOP_SPEED: begin
            quot_nxt = SPEED_NUM;
            div_nxt  = DIVR_W'(speed_r);
          end
          DOP_ENGINE: begin
            quot_nxt = ENGINE_NUM;
            div_nxt  = prod_r;
          end
          DOP_AIRFLOW: begin
            quot_nxt = AIRFLOW_NUM;
            div_nxt  = prod_r;
          end
          default: ;
        endcase
      end

      ST_DIV: begin
        // dividend bits shift out the top, quotient bits shift in the bottom
        rem_nxt  = trial_ge ? trial_diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
        quot_nxt = {quot_r[QUOT_W-2:0], trial_ge};
        cnt_nxt  = cnt_r + 1'b1;
      end

      ST_DSTORE: begin
        unique case (op_r)
          DOP_SPEED: begin
            hp_nxt[0] = ((quot_r >> PERIOD_BITS) != '0) ? PERIOD_MAX : PERIOD_BITS'(quot_r);
            op_nxt    = DOP_ENGINE;
          end
          DOP_ENGINE: begin
            hp_nxt[1] = ((quot_r >> PERIOD_BITS) != '0) ? PERIOD_MAX : PERIOD_BITS'(quot_r);
            op_nxt    = DOP_AIRFLOW;
          end
          DOP_AIRFLOW: begin
            hp_nxt[2] = ((quot_r >> PERIOD_BITS) != '0) ? PERIOD_MAX : PERIOD_BITS'(quot_r);
          end
          default: ;
        endcase
      end

      ST_CHAN: begin
        // toggle once the count reaches a nonzero half period
        for (int i = 0; i < 3; i++) begin
          if (hp_r[i] != '0 && ch_el_r[i] >= hp_r[i]) begin
            level_nxt[i] = ~level_r[i];
            ch_el_nxt[i] = '0;
          end else if (ch_el_r[i] != PERIOD_MAX) begin
            ch_el_nxt[i] = ch_el_r[i] + 1'b1;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.speed_pulse   = level_r[0];
          out_data_nxt.rpm_pulse     = level_r[1];
          out_data_nxt.airflow_pulse = level_r[2];
          out_data_nxt.speed_kmh     = speed_r;
          out_data_nxt.engine_rpm    = rpm_r;
          out_data_nxt.gear_index    = gear_r;
        end
      end

      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequential
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      update_interval_r <= UPDATE_INTERVAL_RST;
      speed_limit_r     <= SPEED_LIMIT_RST;
      shift_rpm_r       <= SHIFT_RPM_RST;
      speed_r           <= SPEED_RST;
      rpm_r             <= '0;
      gear_r            <= '0;
      interval_r        <= '0;
      for (int i = 0; i < 3; i++) begin
        hp_r[i]    <= '0;
        ch_el_r[i] <= '0;
      end
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      rpm_r       <= rpm_nxt;
      gear_r      <= gear_nxt;
      interval_r  <= interval_nxt;
      hp_r        <= hp_nxt;
      ch_el_r     <= ch_el_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_UPDATE_INTERVAL: update_interval_r <= cfg_data;
          CFG_SPEED_LIMIT:     speed_limit_r     <= cfg_data[SPEED_W-1:0];
          CFG_SHIFT_RPM:       shift_rpm_r       <= cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    plus_r     <= plus_nxt;
    minus_r    <= minus_nxt;
    prod_r     <= prod_nxt;
    lim_r      <= lim_nxt;
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
    op_r       <= op_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an accepted transaction either recomputes or goes straight to the wave update
  a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SPEED || state_r == ST_CHAN))
    else $error("accepted transaction took an unexpected path");

  // leaving the emit step always leaves a result pending
  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("emit step did not load the result register");

  // speed only moves in the button sampling step
  a_speed_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(speed_r)) |-> $past(state_r) == ST_SPEED)
    else $error("speed changed outside the sampling step");

  // at zero speed all waves are stopped once a recompute has finished
  a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (speed_r == '0 && (state_r == ST_IDLE || state_r == ST_CHAN || state_r == ST_EMIT))
      |-> (hp_r[0] == '0 && hp_r[1] == '0 && hp_r[2] == '0))
    else $error("half period nonzero at zero speed");

endmodule
